>>> src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, codes and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Fixed field widths and allocator constants
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned ADDR_BITS       = 32;
  // Width of break + header + size, wide enough never to wrap
  localparam int unsigned NB_W            = DATA_W + 2;

  localparam logic [DATA_W-1:0] HEAP_BASE_RST  = 32'd65536;
  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd131072;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] user_address;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_address;
    status_e           status;
  } rsp_t;

  // One block table entry as stored in the RAM
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
    logic              free;
  } entry_t;

endpackage

>>> src/ffa_stream_if.sv
// ----------------------------------------------------------------------------
// ffa_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ffa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator serving allocate and free requests.
// ----------------------------------------------------------------------------
// The block keeps an address-ordered table of heap blocks in one RAM and
// serves one request at a time. An allocate reuses the first free block that
// is large enough, else appends a block at the break (header plus size);
// a free pops the last block or marks another block free. The table is walked
// one entry per cycle through the RAM's single registered read port, and the
// request channel is ready only between requests. The finished response word
// sits in an output register, so the next request may be taken while it
// waits. The user must write configuration only while no request is in
// flight; the block itself does not enforce it.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffa_stream_if.sink                    req_i,
  ffa_stream_if.source                  rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffa_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import ffa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] size_q, size_d;
  logic [DATA_W-1:0] uaddr_q, uaddr_d;
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_ptr_q, chk_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] brk_q, brk_d;
  logic [DATA_W-1:0] base_q, base_d;
  logic [DATA_W-1:0] limit_q, limit_d;
  logic [DATA_W-1:0] res_addr_q, res_addr_d;
  status_e           res_st_q, res_st_d;
  logic              out_vld_q, out_vld_d;
  rsp_t              out_data_q, out_data_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic              hit;
  logic [DATA_W-1:0] hit_uaddr;
  logic              rd_issue;
  logic              req_null;
  logic [NB_W-1:0]   new_brk;
  logic              addr_ovf;
  logic [DATA_W:0]   grow_uaddr;

  // Block table
  ffa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Entry compare against the pending request
  ffa_match u_match (
    .op_i        (op_q),
    .req_size_i  (size_q),
    .req_addr_i  (uaddr_q),
    .entry_i     (rd_entry),
    .hit_o       (hit),
    .user_addr_o (hit_uaddr)
  );

  assign rd_issue   = (rd_ptr_q != cnt_q);
  assign new_brk    = NB_W'(brk_q) + NB_W'(HEADER_BYTES) + NB_W'(size_q);
  assign addr_ovf   = (ADDR_BITS < NB_W) ? |(new_brk >> ADDR_BITS) : 1'b0;
  assign grow_uaddr = {1'b0, brk_q} + (DATA_W+1)'(HEADER_BYTES);
  assign req_null   = (req_i.data.operation == OP_FREE) ?
                      (req_i.data.user_address == '0) : (req_i.data.request_size == '0);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_data_q;

  // Sequencer: latch request, walk table, grow heap, hand off response word
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    size_d     = size_q;
    uaddr_d    = uaddr_q;
    rd_ptr_d   = rd_ptr_q;
    chk_vld_d  = chk_vld_q;
    chk_ptr_d  = chk_ptr_q;
    cnt_d      = cnt_q;
    brk_d      = brk_q;
    base_d     = base_q;
    limit_d    = limit_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_ptr_q;
    ram_wdata  = rd_entry;

    // Drop the response word once taken
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        rd_ptr_d  = '0;
        chk_vld_d = 1'b0;
        if (req_i.valid) begin
          op_d    = req_i.data.operation;
          size_d  = req_i.data.request_size;
          uaddr_d = req_i.data.user_address;
          if (req_null) begin
            res_addr_d = '0;
            res_st_d   = ST_NULL;
            state_d    = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while checking the previous one
        chk_vld_d = rd_issue;
        chk_ptr_d = rd_ptr_q[IDX_W-1:0];
        if (rd_issue) begin
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end
        if (chk_vld_q && hit) begin
          chk_vld_d = 1'b0;
          res_st_d  = ST_OK;
          state_d   = S_DONE;
          if (op_q == OP_ALLOC) begin
            ram_we         = 1'b1;
            ram_wdata.free = 1'b0;
            res_addr_d     = hit_uaddr;
          end else begin
            res_addr_d = '0;
            if (CNT_W'(chk_ptr_q) + CNT_W'(1) == cnt_q) begin
              cnt_d = cnt_q - CNT_W'(1);
              brk_d = rd_entry.start;
            end else begin
              ram_we         = 1'b1;
              ram_wdata.free = 1'b1;
            end
          end
        end else if (!chk_vld_q && !rd_issue) begin
          if (op_q == OP_ALLOC) begin
            state_d = S_GROW;
          end else begin
            res_addr_d = '0;
            res_st_d   = ST_UNKNOWN;
            state_d    = S_DONE;
          end
        end
      end

      S_GROW: begin
        state_d = S_DONE;
        if ((new_brk > NB_W'(limit_q)) || addr_ovf) begin
          res_addr_d = '0;
          res_st_d   = ST_LIMIT;
        end else if (cnt_q == CNT_W'(MAX_BLOCKS)) begin
          res_addr_d = '0;
          res_st_d   = ST_FULL;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = cnt_q[IDX_W-1:0];
          ram_wdata.start = brk_q;
          ram_wdata.size  = size_q;
          ram_wdata.free  = 1'b0;
          cnt_d           = cnt_q + CNT_W'(1);
          brk_d           = new_brk[DATA_W-1:0];
          res_addr_d      = grow_uaddr[DATA_W-1:0];
          res_st_d        = ST_OK;
        end
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d                 = 1'b1;
          out_data_d.result_address = res_addr_q;
          out_data_d.status         = res_st_q;
          state_d                   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Register writes; the break follows the base while the table is empty
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAP_BASE: begin
          base_d = cfg_wdata_i;
          if (cnt_q == '0) begin
            brk_d = cfg_wdata_i;
          end
        end
        CFG_HEAP_LIMIT: limit_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_ALLOC;
      size_q     <= '0;
      uaddr_q    <= '0;
      rd_ptr_q   <= '0;
      chk_vld_q  <= 1'b0;
      chk_ptr_q  <= '0;
      cnt_q      <= '0;
      brk_q      <= HEAP_BASE_RST;
      base_q     <= HEAP_BASE_RST;
      limit_q    <= HEAP_LIMIT_RST;
      res_addr_q <= '0;
      res_st_q   <= ST_OK;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      size_q     <= size_d;
      uaddr_q    <= uaddr_d;
      rd_ptr_q   <= rd_ptr_d;
      chk_vld_q  <= chk_vld_d;
      chk_ptr_q  <= chk_ptr_d;
      cnt_q      <= cnt_d;
      brk_q      <= brk_d;
      base_q     <= base_d;
      limit_q    <= limit_d;
      res_addr_q <= res_addr_d;
      res_st_q   <= res_st_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
    end
  end

  // Table never holds more blocks than it has rows
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  // Table is written only while a request is being served
  a_ram_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN || state_q == S_GROW))
    else $error("table write outside a request");

  // A failed request never carries an address
  a_fail_null_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q.status != ST_OK) |-> out_data_q.result_address == '0)
    else $error("failed response with nonzero address");

  // Count changes only in a request step (scan or grow), by at most one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_d != cnt_q) |-> (state_q == S_SCAN || state_q == S_GROW))
    else $error("block count changed outside a request");
endmodule

>>> src/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/ffa_match.sv
// ----------------------------------------------------------------------------
// ffa_match
// Shared compare unit: tests one table entry against the pending request.
// ----------------------------------------------------------------------------
module ffa_match (
  input  ffa_pkg::op_e                 op_i,
  input  logic [ffa_pkg::DATA_W-1:0]   req_size_i,
  input  logic [ffa_pkg::DATA_W-1:0]   req_addr_i,
  input  ffa_pkg::entry_t              entry_i,
  output logic                         hit_o,
  output logic [ffa_pkg::DATA_W-1:0]   user_addr_o
);
  import ffa_pkg::*;

  logic [DATA_W:0] user_addr_full;

  // User address sits one header past the block start
  assign user_addr_full = {1'b0, entry_i.start} + (DATA_W+1)'(HEADER_BYTES);
  assign user_addr_o    = user_addr_full[DATA_W-1:0];

  // Allocate looks for a free block large enough; free looks for the address
  always_comb begin
    unique case (op_i)
      OP_ALLOC: hit_o = entry_i.free && (entry_i.size >= req_size_i);
      OP_FREE:  hit_o = (user_addr_full == {1'b0, req_addr_i});
      default:  hit_o = 1'b0;
    endcase
  end
endmodule

>>> tb/heap_alloc_checker.sv
// ----------------------------------------------------------------------------
// heap_alloc_checker
// Tracks the allocator's block table and checks every response word.
// ----------------------------------------------------------------------------
// Keeps its own copy of the heap table, the break and the two heap registers.
// Each accepted request word is served against that copy and the expected
// response is queued. Each accepted response word is compared field by field
// with the oldest queued one. The number of queued responses and the failure
// count go back to the testbench top.
module heap_alloc_checker
  import ffa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  req_t                 req_data_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  rsp_t                 rsp_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  output int unsigned          outstanding_o,
  output int unsigned          failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     REPORT_MAX = 10;
  localparam logic [NB_W-1:0] ADDR_TOP   = (NB_W'(1) << ADDR_BITS) - NB_W'(1);

  // Shadow heap table and registers
  logic [DATA_W-1:0] blk_start [MAX_BLOCKS_DEF];
  logic [DATA_W-1:0] blk_size  [MAX_BLOCKS_DEF];
  logic              blk_free  [MAX_BLOCKS_DEF];
  int unsigned       blk_count;
  logic [DATA_W-1:0] heap_brk;
  logic [DATA_W-1:0] base_reg;
  logic [DATA_W-1:0] limit_reg;

  rsp_t        pending_rsp_q[$];
  rsp_t        oldest_rsp;
  int unsigned fail_count;

  // Serve one request against the shadow table and return its response
  function automatic rsp_t serve_request(input req_t w);
    rsp_t              r;
    logic [NB_W-1:0]   grown;
    bit                hit;
    int unsigned       i;
    r.result_address = '0;
    r.status         = ST_OK;
    hit              = 1'b0;
    if (w.operation == OP_ALLOC) begin
      if (w.request_size == '0) begin
        r.status = ST_NULL;
      end else begin
        // first fit: take the lowest free block that is large enough, no split
        for (i = 0; i < blk_count; i++) begin
          if (!hit && blk_free[i] && blk_size[i] >= w.request_size) begin
            blk_free[i]      = 1'b0;
            r.result_address = blk_start[i] + HEADER_BYTES;
            hit              = 1'b1;
          end
        end
        // no fit: grow at the break, limit checked before table space
        if (!hit) begin
          grown = NB_W'(heap_brk) + NB_W'(HEADER_BYTES) + NB_W'(w.request_size);
          if (grown > NB_W'(limit_reg) || grown > ADDR_TOP) begin
            r.status = ST_LIMIT;
          end else if (blk_count >= MAX_BLOCKS_DEF) begin
            r.status = ST_FULL;
          end else begin
            blk_start[blk_count] = heap_brk;
            blk_size[blk_count]  = w.request_size;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            r.result_address = heap_brk + HEADER_BYTES;
            heap_brk         = grown[DATA_W-1:0];
          end
        end
      end
    end else if (w.user_address == '0) begin
      r.status = ST_NULL;
    end else begin
      // pop the last block, mark any other one free
      for (i = 0; i < blk_count; i++) begin
        if (!hit && NB_W'(blk_start[i]) + NB_W'(HEADER_BYTES) == NB_W'(w.user_address)) begin
          hit = 1'b1;
          if (i + 1 == blk_count) begin
            heap_brk = blk_start[i];
            blk_count--;
          end else begin
            blk_free[i] = 1'b1;
          end
        end
      end
      if (!hit) r.status = ST_UNKNOWN;
    end
    return r;
  endfunction

  task automatic flag_failure(input string what, input rsp_t want, input rsp_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t heap_alloc_checker: %s: expected addr %h status %0d, got addr %h status %0d",
               $time, what, want.result_address, want.status, got.result_address, got.status);
    end
  endtask

  // Track config writes, check responses, then queue predictions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_reg  = HEAP_BASE_RST;
      limit_reg = HEAP_LIMIT_RST;
      heap_brk  = HEAP_BASE_RST;
      blk_count = 0;
      fail_count = 0;
      pending_rsp_q.delete();
      outstanding_o <= 0;
      failures_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) begin
          base_reg = cfg_wdata_i;
          // an empty table moves the break along with the base
          if (blk_count == 0) heap_brk = cfg_wdata_i;
        end else if (cfg_idx_i == CFG_HEAP_LIMIT) begin
          limit_reg = cfg_wdata_i;
        end
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_rsp_q.size() == 0) begin
          oldest_rsp = '0;
          flag_failure("response word with none expected", oldest_rsp, rsp_data_i);
        end else begin
          oldest_rsp = pending_rsp_q.pop_front();
          if (rsp_data_i.result_address !== oldest_rsp.result_address)
            flag_failure("result_address mismatch", oldest_rsp, rsp_data_i);
          if (rsp_data_i.status !== oldest_rsp.status)
            flag_failure("status mismatch", oldest_rsp, rsp_data_i);
        end
      end
      if (req_valid_i && req_ready_i) pending_rsp_q.push_back(serve_request(req_data_i));
      outstanding_o <= pending_rsp_q.size();
      failures_o    <= fail_count;
    end
  end

endmodule

>>> tb/tb_first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Stimulus and verdict for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// Runs a directed sequence over null requests, reuse, pops, unknown addresses
// and the heap limit, then random phases under several heap base and limit
// settings with random gaps on both channels and one long response stall.
// Free addresses come mostly from addresses the allocator handed out. The
// checker beside the block predicts and compares every response word.
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned NUM_PHASES      = 11;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned RSP_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = MAX_BLOCKS_DEF + 16;
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned ADDR_POOL_MAX   = 96;
  localparam logic [DATA_W-1:0] DIR_BASE  = 32'h0000_1000;
  localparam logic [DATA_W-1:0] DIR_LIMIT = 32'h0000_2000;
  // after the directed pops the break sits 0x85 above the base
  localparam logic [DATA_W-1:0] DIR_FILL  = DIR_LIMIT - DIR_BASE - 32'h85 - HEADER_BYTES;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;
  int unsigned          outstanding;
  int unsigned          failures;
  int unsigned          quiet_cycles = 0;
  bit                   no_idle;
  bit                   rsp_hold_req;
  logic [DATA_W-1:0]    addr_pool[$];

  ffa_stream_if #(.payload_t(req_t)) req_if ();
  ffa_stream_if #(.payload_t(rsp_t)) rsp_if ();

  first_fit_heap_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  heap_alloc_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_data_i    (req_if.data),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_data_i    (rsp_if.data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .failures_o    (failures)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, a few long
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic req_t alloc_word(input logic [DATA_W-1:0] size);
    req_t w;
    w.operation    = OP_ALLOC;
    w.request_size = size;
    w.user_address = $urandom;
    return w;
  endfunction

  function automatic req_t free_word(input logic [DATA_W-1:0] addr);
    req_t w;
    w.operation    = OP_FREE;
    w.request_size = $urandom;
    w.user_address = addr;
    return w;
  endfunction

  // Mostly real traffic: small sizes and frees of handed-out addresses
  function automatic req_t random_word(input int unsigned alloc_pct, input bit small_only);
    int unsigned       pick;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) size = '0;
      else if (small_only && pick < 97) size = $urandom_range(1, 32);
      else if (pick < 60) size = $urandom_range(1, 64);
      else if (pick < 85) size = $urandom_range(65, 1024);
      else if (pick < 95) size = $urandom_range(1025, 8192);
      else size = $urandom;
      return alloc_word(size);
    end
    pick = $urandom_range(0, 99);
    if (pick < 80 && addr_pool.size() != 0)
      addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    else if (pick < 86)
      addr = '0;
    else if (pick < 93 && addr_pool.size() != 0)
      addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)] + $urandom_range(1, 15);
    else
      addr = $urandom;
    return free_word(addr);
  endfunction

  // Offer one request word after a random gap and hold it until taken
  task automatic offer_word(input req_t w);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and wait for every expected response word
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_heap(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HEAP_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_idx   <= CFG_HEAP_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Main stimulus and verdict
  initial begin : stimulus
    req_t              dir_q[$];
    int unsigned       ph;
    int unsigned       n;
    int unsigned       alloc_pct;
    bit                small_only;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] limit;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_HEAP_BASE;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    no_idle      = 1'b0;
    rsp_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: base moves the break of the empty table
    program_heap(DIR_BASE, DIR_LIMIT);
    dir_q.push_back(alloc_word('0));                  // null allocate
    dir_q.push_back(free_word('0));                   // null free
    dir_q.push_back(free_word(DIR_BASE + 32'h10));    // unknown, table empty
    dir_q.push_back(alloc_word(32'd1));               // block 0
    dir_q.push_back(alloc_word(32'd100));             // block 1
    dir_q.push_back(alloc_word(32'd8));               // block 2
    dir_q.push_back(alloc_word(32'hFFFF_FFFF));       // past limit and address space
    dir_q.push_back(free_word(DIR_BASE + 32'h10));    // mark block 0 free
    dir_q.push_back(free_word(DIR_BASE + 32'h10));    // free it again
    dir_q.push_back(alloc_word(32'd1));               // reuse block 0
    dir_q.push_back(free_word(DIR_BASE + 32'h21));    // mark block 1 free
    dir_q.push_back(alloc_word(32'd50));              // reuse block 1 unsplit
    dir_q.push_back(alloc_word(32'd200));             // no fit, append block 3
    dir_q.push_back(free_word(DIR_BASE + 32'hAD));    // pop block 3
    dir_q.push_back(free_word(DIR_BASE + 32'h95));    // pop block 2
    dir_q.push_back(free_word(DIR_BASE + 32'h95));    // gone now, unknown
    dir_q.push_back(free_word(DIR_BASE + 32'h22));    // off by one, unknown
    dir_q.push_back(free_word(32'hFFFF_FFFF));        // unknown
    dir_q.push_back(alloc_word(DIR_FILL));            // break lands on the limit
    dir_q.push_back(alloc_word(32'd1));               // limit reached
    dir_q.push_back(free_word(DIR_BASE + 32'h95));    // pop the fill block
    dir_q.push_back(alloc_word(DIR_FILL + 1));        // one byte over the limit
    dir_q.push_back(alloc_word(DIR_FILL));            // exact fit again
    foreach (dir_q[i]) offer_word(dir_q[i]);

    // Random phases, each under its own heap settings
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      alloc_pct  = 65;
      small_only = 1'b0;
      no_idle    = 1'b0;
      case (ph)
        0: begin base = HEAP_BASE_RST; limit = HEAP_LIMIT_RST; alloc_pct = 70; end
        1: begin
          base = 32'h2000_0000; limit = 32'h2001_0000;
          alloc_pct = 85; small_only = 1'b1; no_idle = 1'b1;
        end
        2: begin base = '0; limit = '0; alloc_pct = 60; end
        3: begin base = '0; limit = 32'hFFFF_FFFF; end
        4: begin base = 32'hFFFF_F000; limit = 32'hFFFF_FFFF; small_only = 1'b1; end
        5: begin base = 32'hFFFF_FFFF; limit = 32'hFFFF_FFFF; alloc_pct = 55; end
        6: begin base = 32'h0000_1000; limit = 32'h0000_1800; alloc_pct = 70; end
        7: begin
          base  = $urandom;
          limit = (base > 32'hFFFD_FFFF) ? 32'hFFFF_FFFF : base + $urandom_range(0, 32'h2_0000);
          alloc_pct = 70;
        end
        8: begin base = 32'h8000_0000; limit = 32'h8000_4000; alloc_pct = 50; no_idle = 1'b1; end
        9: begin base = HEAP_BASE_RST; limit = HEAP_LIMIT_RST; alloc_pct = 75; small_only = 1'b1; end
        default: begin base = '0; limit = 32'h0001_0000; alloc_pct = 40; end
      endcase
      program_heap(base, limit);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // stall the response side for a long stretch once
        if (ph == 0 && n == 40) rsp_hold_req = 1'b1;
        offer_word(random_word(alloc_pct, small_only));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_first_fit_heap_allocator OK");
    end else begin
      $display("tb_first_fit_heap_allocator NOT OK");
    end
    $finish;
  end

  // Response ready: random gaps, plus one long hold-off on request
  initial begin : response_pacing
    int unsigned gap;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Collect handed-out addresses for later frees
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready && rsp_if.data.status == ST_OK &&
        rsp_if.data.result_address != '0) begin
      addr_pool.push_back(rsp_if.data.result_address);
      if (addr_pool.size() > ADDR_POOL_MAX) addr_pool.delete($urandom_range(0, ADDR_POOL_MAX));
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb_first_fit_heap_allocator NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> filelist.f
src/ffa_pkg.sv
src/ffa_stream_if.sv
src/ffa_ram.sv
src/ffa_match.sv
src/first_fit_heap_allocator.sv
tb/heap_alloc_checker.sv
tb/tb_first_fit_heap_allocator.sv
